@@ sv/fsr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_pkg
// Shared types and constants for the stuffed frame receiver.
// ----------------------------------------------------------------------------
package fsr_pkg;

    localparam int          DEFAULT_MAX_FRAME = 64;
    localparam int          POS_W             = 7;
    localparam int          HDR_LEN           = 5;
    localparam int          FIFO_DEPTH        = 8;
    localparam int          FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0]  BYTE_TERM         = 8'hFF;
    localparam logic [7:0]  BYTE_SYNC_ID      = 8'hFD;
    localparam logic [7:0]  BYTE_SYNC_MARK    = 8'h55;
    localparam logic [7:0]  BYTE_DATA_ID      = 8'h83;
    localparam logic [7:0]  BYTE_DATA_KIND    = 8'hFE;
    localparam logic [7:0]  BYTE_ESC          = 8'hFA;
    localparam logic [7:0]  ESC_OFFSET        = 8'h80;

    typedef enum logic [2:0] {
        ST_PROGRESS = 3'd0,
        ST_SYNC     = 3'd1,
        ST_DATA_OK  = 3'd2,
        ST_DATA_BAD = 3'd3,
        ST_OTHER    = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_end;
        t_status     frame_status;
        logic [7:0]  frame_number;
        logic [15:0] fault_count;
        logic        last;
    } t_result;

    // up to two results per received byte
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  empty;
    } t_fifo_stat;

endpackage

@@ sv/fsr_frame_proc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_frame_proc
// Per-byte destuffing, frame classification and checksum; holds frame state.
// ----------------------------------------------------------------------------
module fsr_frame_proc #(
    parameter int MAX_FRAME = fsr_pkg::DEFAULT_MAX_FRAME
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    output fsr_pkg::t_push o_push
);
    import fsr_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_FRAME - 1);

    logic [POS_W-1:0] r_pos,  n_pos;
    logic [7:0]       r_hdr [HDR_LEN];
    logic [7:0]       n_hdr [HDR_LEN];
    logic [7:0]       r_sum,  n_sum;
    logic             r_esc,  n_esc;
    logic             r_ovf,  n_ovf;
    logic [7:0]       r_sync, n_sync;
    logic [15:0]      r_bad,  n_bad;

    function automatic t_result mk(input logic [7:0] data, input logic fend,
                                   input t_status st, input logic [7:0] num,
                                   input logic [15:0] cnt, input logic fin);
        t_result r;
        r.data_byte    = data;
        r.frame_end    = fend;
        r.frame_status = st;
        r.frame_number = num;
        r.fault_count  = cnt;
        r.last         = fin;
        return r;
    endfunction

    always_comb begin
        logic [7:0] sum;
        t_status    st;
        n_pos  = r_pos;
        n_hdr  = r_hdr;
        n_sum  = r_sum;
        n_esc  = r_esc;
        n_ovf  = r_ovf;
        n_sync = r_sync;
        n_bad  = r_bad;
        sum    = r_sum;
        st     = ST_OTHER;
        o_push.count = 2'd0;
        o_push.r0    = mk(i_byte, 1'b0, ST_PROGRESS, r_sync, r_bad, 1'b1);
        o_push.r1    = mk(BYTE_TERM, 1'b1, ST_PROGRESS, r_sync, r_bad, 1'b1);

        if (i_valid) begin
            if (i_byte == BYTE_TERM) begin
                if (r_pos >= POS_W'(2)) begin
                    sum = r_sum + BYTE_TERM;
                end
                if (r_ovf) begin
                    st = ST_OVERFLOW;
                end else if (r_pos >= POS_W'(5) && r_hdr[2] == BYTE_SYNC_ID &&
                             r_hdr[4] == BYTE_SYNC_MARK) begin
                    st     = ST_SYNC;
                    n_sync = r_hdr[3];
                end else if (r_pos >= POS_W'(3) && r_hdr[0] == BYTE_DATA_ID &&
                             r_hdr[1] == BYTE_DATA_ID &&
                             r_hdr[2] == BYTE_DATA_KIND) begin
                    if (sum == 8'd0) begin
                        st = ST_DATA_OK;
                    end else begin
                        st = ST_DATA_BAD;
                        if (r_bad != 16'hFFFF) begin
                            n_bad = r_bad + 16'd1;
                        end
                    end
                end
                if (r_esc && !r_ovf) begin
                    // pending escape is flushed as a plain 0xFA ahead of the end
                    o_push.count = 2'd2;
                    o_push.r0    = mk(BYTE_ESC, 1'b0, ST_PROGRESS, n_sync, n_bad, 1'b0);
                    o_push.r1    = mk(BYTE_TERM, 1'b1, st, n_sync, n_bad, 1'b1);
                end else begin
                    o_push.count = 2'd1;
                    o_push.r0    = mk(BYTE_TERM, 1'b1, st, n_sync, n_bad, 1'b1);
                end
                n_pos = '0;
                n_sum = 8'd0;
                n_esc = 1'b0;
                n_ovf = 1'b0;
            end else if (r_pos >= LAST_POS) begin
                n_ovf = 1'b1;          // dropped
            end else begin
                for (int k = 0; k < HDR_LEN; k++) begin
                    if (r_pos == POS_W'(k)) begin
                        n_hdr[k] = i_byte;
                    end
                end
                if (r_pos >= POS_W'(2)) begin
                    n_sum = r_sum + i_byte;
                end
                n_pos = r_pos + POS_W'(1);
                if (r_pos < POS_W'(4)) begin
                    o_push.count = 2'd1;
                end else if (r_esc) begin
                    n_esc        = 1'b0;
                    o_push.count = 2'd1;
                    o_push.r0    = mk(i_byte + ESC_OFFSET, 1'b0, ST_PROGRESS,
                                      r_sync, r_bad, 1'b1);
                end else if (i_byte == BYTE_ESC) begin
                    n_esc = 1'b1;
                end else begin
                    o_push.count = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= 8'd0;
            r_esc  <= 1'b0;
            r_ovf  <= 1'b0;
            r_sync <= 8'd0;
            r_bad  <= 16'd0;
            for (int k = 0; k < HDR_LEN; k++) begin
                r_hdr[k] <= 8'd0;
            end
        end else begin
            r_pos  <= n_pos;
            r_hdr  <= n_hdr;
            r_sum  <= n_sum;
            r_esc  <= n_esc;
            r_ovf  <= n_ovf;
            r_sync <= n_sync;
            r_bad  <= n_bad;
        end
    end

endmodule

@@ sv/fsr_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_out_fifo
// Result queue: takes zero to two words per cycle, hands out one.
// ----------------------------------------------------------------------------
module fsr_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsr_pkg::t_push      i_push,
    input  logic                i_pop,
    output logic                o_valid,
    output fsr_pkg::t_result    o_data,
    output fsr_pkg::t_fifo_stat o_stat
);
    import fsr_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_result               r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]      r_wp, n_wp;
    logic [PTR_W-1:0]      r_rp, n_rp;
    logic [FIFO_CNT_W-1:0] r_cnt, n_cnt;
    logic [PTR_W-1:0]      wp1;

    assign wp1 = r_wp + PTR_W'(1);

    always_comb begin
        n_wp  = r_wp + PTR_W'(i_push.count);
        n_rp  = r_rp + PTR_W'(i_pop);
        n_cnt = r_cnt + FIFO_CNT_W'(i_push.count) - FIFO_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    assign o_valid      = (r_cnt != '0);
    assign o_data       = r_mem[r_rp];
    assign o_stat.count = r_cnt;
    assign o_stat.empty = (r_cnt == '0);

endmodule

@@ sv/stuffed_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_unit
// Byte-stuffed frame receiver: destuffs, classifies frames at 0xFF, checks
// the additive checksum of data frames and counts bad ones.
// ----------------------------------------------------------------------------
//  port group  | dir | word contents
//  ------------+-----+---------------------------------------------------------
//  s_axis      | in  | tdata[7:0] rx_byte
//  m_axis      | out | tdata data_byte/frame_status/frame_number/fault_count,
//              |     | tlast frame_end, tuser last
//
//  Throughput: one byte per cycle while s_axis tready is high. A terminator
//  that follows a pending escape yields two words; the output side drains one
//  word per cycle while m_axis tready is high. An accepted byte passes the
//  input register, then the result queue, before its first word is output.
//  Reset: synchronous, active low; clears frame state, counters and queue.
//  Stalls: tready drops only when the result queue could not take the words
//  of the byte in flight plus two more.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_unit #(
    parameter int MAX_FRAME = fsr_pkg::DEFAULT_MAX_FRAME
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] data_byte, [10:8] frame_status, [18:11] frame_number,
    // [34:19] fault_count, [39:35] zero
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,    // frame_end
    output logic        o_m_axis_tuser     // [0] last
);
    import fsr_pkg::*;

    localparam int SUM_W = FIFO_CNT_W + 1;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        s_accept;
    logic        m_pop;
    t_push       push;
    t_result     head;
    t_fifo_stat  fstat;
    logic [SUM_W-1:0] committed;

    // words already queued plus worst case for the byte in the input register
    assign committed = SUM_W'(fstat.count) + (r_in_valid ? SUM_W'(2) : SUM_W'(0));
    assign o_s_axis_tready = (committed <= SUM_W'(FIFO_DEPTH - 2));
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= s_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    fsr_frame_proc #(
        .MAX_FRAME (MAX_FRAME)
    ) u_proc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    assign m_pop = o_m_axis_tvalid && i_m_axis_tready;

    fsr_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_pop),
        .o_valid (o_m_axis_tvalid),
        .o_data  (head),
        .o_stat  (fstat)
    );

    assign o_m_axis_tdata = {5'd0, head.fault_count, head.frame_number,
                             head.frame_status, head.data_byte};
    assign o_m_axis_tlast = head.frame_end;
    assign o_m_axis_tuser = head.last;

`ifndef ASSERT_OFF
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fstat.count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overrun");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count == 2'd2 |-> !push.r0.last && push.r1.last && push.r1.frame_end)
        else $error("escape flush pair out of order");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser)
        else $error("frame end word not marked last");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

@@ sim/stuffed_frame_receiver_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_unit_test
// Self-checking bench for the stuffed frame receiver. Raw line bytes are
// queued up front (a short directed set, random frames and a short burst of
// bad data frames streamed back to back with the output held ready),
// streamed in with random gaps, and every output word is checked field by
// field against an in-bench destuffer/classifier that keeps its own copy of
// the frame state.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_unit_test;
    import fsr_pkg::*;

    localparam int FRAME_CAP    = DEFAULT_MAX_FRAME;
    localparam int RANDOM_BYTES = 1280;
    localparam int BURST_FRAMES = 32;
    localparam int DRAIN_CYCLES = 16;
    localparam int FLUSH_LIMIT  = 10000;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int MAX_REPORTS  = 40;

    typedef enum int {
        FK_SYNC, FK_DATA_GOOD, FK_DATA_BAD, FK_SHORT, FK_NOISE, FK_LONG
    } t_frame_kind;

    typedef struct packed {
        logic [7:0] rx;
        logic       quiet;    // part of the back-to-back burst: no idling
    } t_line_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    t_line_byte  line_q[$];
    t_result     frame_words_q[$];

    // destuffer / classifier state
    logic [6:0]  rcv_pos;
    logic [7:0]  hdr_bytes[HDR_LEN];
    logic [7:0]  csum;
    logic        esc_wait;
    logic        ovf_flag;
    logic [7:0]  sync_no;
    logic [15:0] bad_count;

    int          status_tally[6];
    int          bytes_taken = 0;
    int          bytes_loaded = 0;
    int          words_checked = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    logic        rush = 1'b0;

    stuffed_frame_receiver_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tlast  (m_axis_tlast),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Expected word generation
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [7:0] d, input logic fend, input t_status st,
                              input logic fin);
        t_result w;
        w.data_byte    = d;
        w.frame_end    = fend;
        w.frame_status = st;
        w.frame_number = sync_no;
        w.fault_count  = bad_count;
        w.last         = fin;
        frame_words_q.push_back(w);
    endtask

    task automatic destuff_classify(input logic [7:0] b);
        logic [7:0] sum;
        logic [6:0] pos;
        t_status    st;
        pos = rcv_pos;
        if (b == BYTE_TERM) begin
            sum = csum;
            if (pos >= 2) sum = sum + BYTE_TERM;
            if (ovf_flag) begin
                st = ST_OVERFLOW;
            end else if (pos >= 5 && hdr_bytes[2] == BYTE_SYNC_ID &&
                         hdr_bytes[4] == BYTE_SYNC_MARK) begin
                sync_no = hdr_bytes[3];
                st = ST_SYNC;
            end else if (pos >= 3 && hdr_bytes[0] == BYTE_DATA_ID &&
                         hdr_bytes[1] == BYTE_DATA_ID && hdr_bytes[2] == BYTE_DATA_KIND) begin
                if (sum == 8'h00) begin
                    st = ST_DATA_OK;
                end else begin
                    st = ST_DATA_BAD;
                    if (bad_count != 16'hFFFF) bad_count = bad_count + 16'd1;
                end
            end else begin
                st = ST_OTHER;
            end
            status_tally[int'(st)]++;
            // a dangling escape is flushed as a plain byte ahead of the terminator
            if (esc_wait && !ovf_flag) queue_word(BYTE_ESC, 1'b0, ST_PROGRESS, 1'b0);
            queue_word(BYTE_TERM, 1'b1, st, 1'b1);
            rcv_pos  = '0;
            csum     = '0;
            esc_wait = 1'b0;
            ovf_flag = 1'b0;
        end else if (pos >= FRAME_CAP - 1) begin
            ovf_flag = 1'b1;    // byte dropped
        end else begin
            if (pos < HDR_LEN) hdr_bytes[pos[2:0]] = b;
            if (pos >= 2) csum = csum + b;
            rcv_pos = pos + 7'd1;
            if (pos < 4) begin
                queue_word(b, 1'b0, ST_PROGRESS, 1'b1);
            end else if (esc_wait) begin
                esc_wait = 1'b0;
                queue_word(b + ESC_OFFSET, 1'b0, ST_PROGRESS, 1'b1);
            end else if (b == BYTE_ESC) begin
                esc_wait = 1'b1;
            end else begin
                queue_word(b, 1'b0, ST_PROGRESS, 1'b1);
            end
        end
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Accept side and output check, both on the rising edge. Prediction
    // runs first; a word can never come out in its byte's own cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                destuff_classify(s_axis_tdata);
                bytes_taken <= bytes_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                words_checked++;
                if (frame_words_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected word, expected none, actual 0x%010h",
                                 $time, m_axis_tdata);
                end else begin
                    w = frame_words_q.pop_front();
                    report_field("data_byte", w.data_byte, m_axis_tdata[7:0]);
                    report_field("frame_status", int'(w.frame_status), m_axis_tdata[10:8]);
                    report_field("frame_number", w.frame_number, m_axis_tdata[18:11]);
                    report_field("fault_count", w.fault_count, m_axis_tdata[34:19]);
                    report_field("frame_end", w.frame_end, m_axis_tlast);
                    report_field("last", w.last, m_axis_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Idle lengths: mostly short, now and then long
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // byte driver, falling edge
    always @(negedge i_clk) begin
        t_line_byte it;
        static int gap_left = 0;
        static int calm_left = 0;
        if (i_rst_n && (!s_axis_tvalid || bytes_taken == bytes_loaded)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (line_q.size() > 0) begin
                it = line_q.pop_front();
                s_axis_tdata  <= it.rx;
                s_axis_tvalid <= 1'b1;
                rush          <= it.quiet;
                bytes_loaded++;
                if (it.quiet) begin
                    gap_left = 0;
                end else if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 199) == 0) begin
                    calm_left = $urandom_range(50, 150);
                end else if ($urandom_range(0, 99) < 35) begin
                    gap_left = idle_len();
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output backpressure, falling edge
    always @(negedge i_clk) begin
        static int stall_left = 0;
        static int calm_left = 0;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rush) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 199) == 0)
                calm_left = $urandom_range(50, 150);
            else if ($urandom_range(0, 99) < 30)
                stall_left = idle_len();
        end
    end

    // hard stop
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time,
                     frame_words_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    task automatic push_bytes(ref logic [7:0] fr[$], input logic quiet);
        foreach (fr[i]) line_q.push_back('{rx: fr[i], quiet: quiet});
    endtask

    // payload byte, biased towards the escape code
    function automatic logic [7:0] payload_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return BYTE_ESC;
        if (r < 25) return 8'h00;
        if (r < 30) return 8'hFE;
        return 8'($urandom_range(0, 254));
    endfunction

    task automatic build_frame(input t_frame_kind k);
        logic [7:0] fr[$];
        logic [7:0] sum, fix;
        int         n;
        bit         tail_esc;
        case (k)
            FK_SYNC: begin
                fr.push_back(8'($urandom_range(0, 254)));
                fr.push_back(8'($urandom_range(0, 254)));
                fr.push_back(BYTE_SYNC_ID);
                fr.push_back(8'($urandom_range(0, 254)));
                fr.push_back(BYTE_SYNC_MARK);
                n = $urandom_range(0, 8);
                repeat (n) fr.push_back(payload_byte());
            end
            FK_DATA_GOOD, FK_DATA_BAD: begin
                fr.push_back(BYTE_DATA_ID);
                fr.push_back(BYTE_DATA_ID);
                fr.push_back(BYTE_DATA_KIND);
                n = $urandom_range(0, 12);
                repeat (n) fr.push_back(payload_byte());
                tail_esc = ($urandom_range(0, 99) < 25);
                if (k == FK_DATA_GOOD) begin
                    // pick a closing byte so raw bytes 2..terminator sum to zero
                    do begin
                        sum = BYTE_TERM + (tail_esc ? BYTE_ESC : 8'h00);
                        for (int i = 2; i < fr.size(); i++) sum = sum + fr[i];
                        fix = 8'h00 - sum;
                        if (fix == BYTE_TERM) fr.push_back(8'h01);
                    end while (fix == BYTE_TERM);
                    fr.push_back(fix);
                end
                if (tail_esc) fr.push_back(BYTE_ESC);
            end
            FK_SHORT: begin
                n = $urandom_range(0, 4);
                case ($urandom_range(0, 2))
                    0: fr = '{BYTE_DATA_ID, BYTE_DATA_ID, BYTE_DATA_KIND, 8'h00};
                    1: fr = '{8'($urandom_range(0, 254)), 8'h00, BYTE_SYNC_ID,
                              8'($urandom_range(0, 254))};
                    default: repeat (4) fr.push_back(payload_byte());
                endcase
                while (fr.size() > n) void'(fr.pop_back());
            end
            FK_NOISE: begin
                n = $urandom_range(0, 20);
                repeat (n) fr.push_back(payload_byte());
            end
            default: begin    // near or over the frame limit
                if ($urandom_range(0, 1))
                    fr = '{BYTE_DATA_ID, BYTE_DATA_ID, BYTE_DATA_KIND};
                else
                    fr = '{8'h00, 8'h00, BYTE_SYNC_ID, 8'h11, BYTE_SYNC_MARK};
                n = $urandom_range(FRAME_CAP - 6, FRAME_CAP + 6);
                while (fr.size() < n) fr.push_back(payload_byte());
            end
        endcase
        fr.push_back(BYTE_TERM);
        push_bytes(fr, 1'b0);
    endtask

    initial begin
        logic [7:0] fr[$];
        int         r, waited;
        rcv_pos   = '0;
        csum      = '0;
        esc_wait  = 1'b0;
        ovf_flag  = 1'b0;
        sync_no   = '0;
        bad_count = '0;
        foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
        foreach (status_tally[i]) status_tally[i] = 0;

        // directed: empty frame; sync; short frame that must not reuse the
        // stale sync mark; good data; bad data through every escape form
        // (escape+byte with wrap, escape+escape, escape+terminator)
        fr = '{BYTE_TERM,
               8'h00, 8'h00, BYTE_SYNC_ID, 8'h07, BYTE_SYNC_MARK, BYTE_TERM,
               8'h01, 8'h02, BYTE_SYNC_ID, 8'h09, BYTE_TERM,
               BYTE_DATA_ID, BYTE_DATA_ID, BYTE_DATA_KIND, 8'h03, BYTE_TERM,
               BYTE_DATA_ID, BYTE_DATA_ID, BYTE_DATA_KIND, 8'h00, BYTE_ESC, 8'hF0,
               BYTE_ESC, BYTE_ESC, BYTE_ESC, BYTE_TERM};
        push_bytes(fr, 1'b0);

        // random frames, mostly well formed
        while (line_q.size() < fr.size() + RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 15)      build_frame(FK_SYNC);
            else if (r < 45) build_frame(FK_DATA_GOOD);
            else if (r < 60) build_frame(FK_DATA_BAD);
            else if (r < 77) build_frame(FK_SHORT);
            else if (r < 95) build_frame(FK_NOISE);
            else             build_frame(FK_LONG);
        end

        // short bad data frames streamed back to back, output always ready
        fr = '{BYTE_DATA_ID, BYTE_DATA_ID, BYTE_DATA_KIND, BYTE_TERM};
        repeat (BURST_FRAMES) push_bytes(fr, 1'b1);
        build_frame(FK_DATA_BAD);
        build_frame(FK_DATA_GOOD);
        build_frame(FK_SYNC);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (line_q.size() != 0 || bytes_taken != bytes_loaded) @(posedge i_clk);
        waited = 0;
        while (frame_words_q.size() != 0 && waited < FLUSH_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (frame_words_q.size() != 0) begin
            mismatch_cnt++;
            $display("%0t: %0d expected words never arrived, next data_byte 0x%02h",
                     $time, frame_words_q.size(), frame_words_q[0].data_byte);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d line bytes, checked %0d words; fault count ended at %0d.",
                 bytes_taken, words_checked, bad_count);
        $display("Frames closed: sync %0d, data ok %0d, data bad %0d, other %0d, overflow %0d.",
                 status_tally[ST_SYNC], status_tally[ST_DATA_OK], status_tally[ST_DATA_BAD],
                 status_tally[ST_OTHER], status_tally[ST_OVERFLOW]);
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
